// ----- rtl/core/fsom_pkg.sv -----
// Shared widths, register codes, reset values and control types of the overlay mixer.
package fsom_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int GAIN_FRAC_BITS = 24;
	localparam int LEVEL_BITS     = 16;
	localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
	localparam int DIGIT_BITS     = 4;
	localparam int DIGITS         = SAMPLE_BITS / DIGIT_BITS;
	localparam int DIGIT_CNT_W    = $clog2(DIGITS);
	localparam int GL_W           = GAIN_W + LEVEL_BITS;
	localparam int ACC_W          = GL_W + SAMPLE_BITS;
	localparam int SCALE_SHIFT    = GAIN_FRAC_BITS + LEVEL_BITS;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = GAIN_W;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_UP   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RAMP_DOWN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX_LEVEL = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_TH = 2'd3;

	localparam logic [GAIN_W-1:0]     RST_RAMP_UP   = GAIN_W'(1268);
	localparam logic [GAIN_W-1:0]     RST_RAMP_DOWN = GAIN_W'(1902);
	localparam logic [LEVEL_BITS-1:0] RST_MIX_LEVEL = LEVEL_BITS'(19661);
	localparam logic [GAIN_W-1:0]     RST_SWITCH_TH = GAIN_W'(16777);
	localparam logic [GAIN_W-1:0]     GAIN_UNITY    = GAIN_W'(1) << GAIN_FRAC_BITS;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [GAIN_W-1:0] gain_t;

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctrl_t;

endpackage

// ----- rtl/core/fading_stereo_overlay_mixer.sv -----
// Top level of the fading stereo overlay mixer: ramp gain, serial scaling, output register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid/in_ready, base_*, overlay_*, ... | request in
//  out     | out_valid/out_ready, mixed_*, gain_now,   | request out
//          | fade_done                                 |
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
// A request passes from acceptance to the output register through the states GAIN,
// which steps the gain, GL, which forms the gain*level product, DIGIT, which runs the
// four digits of the digit-serial product with the sample magnitude (4 bits per cycle),
// and FIN, which finishes. A new request is taken only once the block is back in IDLE.
// Reset clears the gain to silence and loads the register defaults.
// A stalled output holds the finished result in the final state until it drains.
module fading_stereo_overlay_mixer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  fsom_pkg::sample_t                    base_left,
	input  fsom_pkg::sample_t                    base_right,
	input  fsom_pkg::sample_t                    overlay_left,
	input  fsom_pkg::sample_t                    overlay_right,
	input  logic                                 overlay_present,
	input  logic                                 target_full,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output fsom_pkg::sample_t                    mixed_left,
	output fsom_pkg::sample_t                    mixed_right,
	output logic [fsom_pkg::GAIN_W-1:0]          gain_now,
	output logic                                 fade_done,
	input  logic                                 cfg_we,
	input  logic [fsom_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fsom_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fsom_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GAIN  = 3'd1;
	localparam logic [2:0] ST_GL    = 3'd2;
	localparam logic [2:0] ST_DIGIT = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]             state_q;
	logic [DIGIT_CNT_W-1:0] cnt_q;

	// configuration registers
	gain_t                 up_step_q;
	gain_t                 down_step_q;
	logic [LEVEL_BITS-1:0] level_q;
	gain_t                 threshold_q;

	gain_t                 gain_q;
	logic [GL_W-1:0]       gl_q;

	// captured request payload
	sample_t               base_left_q;
	sample_t               base_right_q;
	logic                  present_q;
	logic                  full_q;

	// output register
	logic                  out_valid_q;
	sample_t               mixed_left_q;
	sample_t               mixed_right_q;
	gain_t                 gain_now_q;
	logic                  fade_done_q;

	logic                  in_fire;
	logic                  out_load;
	mul_ctrl_t             mul_ctrl;
	sample_t               scaled_mix_left;
	sample_t               scaled_mix_right;

	gain_t                 target;
	gain_t                 gain_next;
	logic [GAIN_W:0]       gain_up_sum;
	gain_t                 gain_diff;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign mul_ctrl.load = in_fire;
	assign mul_ctrl.step = (state_q == ST_DIGIT);

	// ramp toward the target, clamp there instead of overshooting
	always_comb begin
		target      = full_q ? GAIN_UNITY : '0;
		gain_up_sum = {1'b0, gain_q} + {1'b0, up_step_q};
		gain_diff   = gain_q - target;
		gain_next   = gain_q;
		if (gain_q < target) begin
			gain_next = (gain_up_sum >= {1'b0, target}) ? target : gain_up_sum[GAIN_W-1:0];
		end else if (gain_q > target) begin
			gain_next = (gain_diff <= down_step_q) ? target : gain_q - down_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_step_q   <= RST_RAMP_UP;
			down_step_q <= RST_RAMP_DOWN;
			level_q     <= RST_MIX_LEVEL;
			threshold_q <= RST_SWITCH_TH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAMP_UP:   up_step_q   <= cfg_data;
				REG_RAMP_DOWN: down_step_q <= cfg_data;
				REG_MIX_LEVEL: level_q     <= cfg_data[LEVEL_BITS-1:0];
				REG_SWITCH_TH: threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: capture, step gain, form gain*level, run digits, drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (present_q) begin
						gain_q <= gain_next;
					end
					state_q <= ST_GL;
				end
				ST_GL: begin
					cnt_q   <= '0;
					state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIGIT_CNT_W'(DIGITS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_left_q  <= base_left;
			base_right_q <= base_right;
			present_q    <= overlay_present;
			full_q       <= target_full;
		end
		if (state_q == ST_GL) begin
			gl_q <= GL_W'(gain_q) * GL_W'(level_q);
		end
		if (out_load) begin
			mixed_left_q  <= present_q ? scaled_mix_left  : base_left_q;
			mixed_right_q <= present_q ? scaled_mix_right : base_right_q;
			gain_now_q    <= gain_q;
			fade_done_q   <= (gain_q <= threshold_q);
		end
	end

	fsom_serial_scale u_scale_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.sample (overlay_left),
		.gl     (gl_q),
		.base   (base_left_q),
		.mixed  (scaled_mix_left)
	);

	fsom_serial_scale u_scale_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mul_ctrl),
		.sample (overlay_right),
		.gl     (gl_q),
		.base   (base_right_q),
		.mixed  (scaled_mix_right)
	);

	assign out_valid   = out_valid_q;
	assign mixed_left  = mixed_left_q;
	assign mixed_right = mixed_right_q;
	assign gain_now    = gain_now_q;
	assign fade_done   = fade_done_q;

endmodule

// ----- rtl/core/fsom_serial_scale.sv -----
// Digit-serial scaling of one overlay channel by gain*level, plus saturated add to the base.
module fsom_serial_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fsom_pkg::mul_ctrl_t        ctrl,
	input  fsom_pkg::sample_t          sample,
	input  logic [fsom_pkg::GL_W-1:0]  gl,
	input  fsom_pkg::sample_t          base,
	output fsom_pkg::sample_t          mixed
);
	import fsom_pkg::*;

	localparam int PP_W  = GL_W + DIGIT_BITS;
	localparam int SUM_W = SAMPLE_BITS + 2;

	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic [ACC_W-1:0]       acc_q;

	logic [SAMPLE_BITS-1:0] mag_in;
	logic [DIGIT_BITS-1:0]  digit;
	logic [PP_W-1:0]        pp;
	logic [SAMPLE_BITS-1:0] scaled;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] scaled_s;

	always_comb begin
		mag_in = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
		digit  = mag_q[SAMPLE_BITS-1 -: DIGIT_BITS];
		pp     = PP_W'(gl) * PP_W'(digit);
	end

	// most significant digit first: shift the partial sum up, add the next product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q <= 1'b0;
		end else if (ctrl.load) begin
			neg_q <= sample[SAMPLE_BITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= mag_in;
			acc_q <= '0;
		end else if (ctrl.step) begin
			mag_q <= mag_q << DIGIT_BITS;
			acc_q <= (acc_q << DIGIT_BITS) + ACC_W'(pp);
		end
	end

	always_comb begin
		scaled   = acc_q[SCALE_SHIFT +: SAMPLE_BITS];
		scaled_s = neg_q ? -SUM_W'(scaled) : SUM_W'(scaled);
		sum      = SUM_W'(base) + scaled_s;
		if (sum[SUM_W-1:SAMPLE_BITS-1] == '0 || sum[SUM_W-1:SAMPLE_BITS-1] == '1) begin
			mixed = sample_t'(sum[SAMPLE_BITS-1:0]);
		end else if (sum[SUM_W-1]) begin
			mixed = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			mixed = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the fading stereo overlay mixer: scoreboard class and drivers.
`timescale 1ns / 1ps

// One input request and one mixed result as the scoreboard sees them.
typedef struct packed {
	fsom_pkg::sample_t base_left;
	fsom_pkg::sample_t base_right;
	fsom_pkg::sample_t overlay_left;
	fsom_pkg::sample_t overlay_right;
	logic              present;
	logic              full;
} frame_t;

typedef struct packed {
	fsom_pkg::sample_t left;
	fsom_pkg::sample_t right;
	fsom_pkg::gain_t   gain;
	logic              done;
} mix_t;

class mix_scoreboard;
	mix_t                            expected_q[$];
	fsom_pkg::gain_t                 gain;
	fsom_pkg::gain_t                 up_step;
	fsom_pkg::gain_t                 down_step;
	fsom_pkg::gain_t                 threshold;
	logic [fsom_pkg::LEVEL_BITS-1:0] level;
	int                              errors;

	function new();
		gain      = '0;
		up_step   = fsom_pkg::RST_RAMP_UP;
		down_step = fsom_pkg::RST_RAMP_DOWN;
		level     = fsom_pkg::RST_MIX_LEVEL;
		threshold = fsom_pkg::RST_SWITCH_TH;
		errors    = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void set_reg(logic [fsom_pkg::CFG_INDEX_W-1:0] idx,
			logic [fsom_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			fsom_pkg::REG_RAMP_UP:   up_step   = val;
			fsom_pkg::REG_RAMP_DOWN: down_step = val;
			fsom_pkg::REG_MIX_LEVEL: level     = val[fsom_pkg::LEVEL_BITS-1:0];
			fsom_pkg::REG_SWITCH_TH: threshold = val;
			default: ;
		endcase
	endfunction

	// base + overlay*gain*level truncated toward zero, then saturated
	function fsom_pkg::sample_t mix_channel(fsom_pkg::sample_t b, fsom_pkg::sample_t o);
		longint mag, part, sum, top, bottom;
		top    = (longint'(1) <<< (fsom_pkg::SAMPLE_BITS - 1)) - 1;
		bottom = -top - 1;
		mag    = (o < 0) ? -longint'(o) : longint'(o);
		part   = (mag * longint'(gain) * longint'(level)) >>> fsom_pkg::SCALE_SHIFT;
		sum    = longint'(b) + ((o < 0) ? -part : part);
		if (sum > top)
			sum = top;
		else if (sum < bottom)
			sum = bottom;
		return fsom_pkg::sample_t'(sum);
	endfunction

	function void note_request(frame_t f);
		longint g, aim;
		mix_t   r;
		g = longint'(gain);
		if (f.present) begin
			aim = f.full ? longint'(fsom_pkg::GAIN_UNITY) : 0;
			if (g < aim)
				g = (g + longint'(up_step) >= aim) ? aim : g + longint'(up_step);
			else if (g > aim)
				g = (g - aim <= longint'(down_step)) ? aim : g - longint'(down_step);
			gain    = fsom_pkg::gain_t'(g);
			r.left  = mix_channel(f.base_left, f.overlay_left);
			r.right = mix_channel(f.base_right, f.overlay_right);
		end else begin
			r.left  = f.base_left;
			r.right = f.base_right;
		end
		r.gain = gain;
		r.done = (gain <= threshold);
		expected_q.push_back(r);
	endfunction

	task report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task check_result(mix_t got);
		mix_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("result with no request outstanding");
			return;
		end
		want = expected_q.pop_front();
		if (got.left !== want.left)
			report_mismatch($sformatf("mixed_left got %0d want %0d", got.left, want.left));
		if (got.right !== want.right)
			report_mismatch($sformatf("mixed_right got %0d want %0d", got.right, want.right));
		if (got.gain !== want.gain)
			report_mismatch($sformatf("gain_now got %0d want %0d", got.gain, want.gain));
		if (got.done !== want.done)
			report_mismatch($sformatf("fade_done got %0b want %0b", got.done, want.done));
	endtask
endclass

module testbench;
	import fsom_pkg::*;

	localparam logic [CFG_DATA_W-1:0] STEP_MAX = '1;
	localparam logic [CFG_DATA_W-1:0] UNITY    = GAIN_UNITY;
	// Cycles to let pass after the last result.
	localparam int SETTLE_CYCLES = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	sample_t                base_left = '0;
	sample_t                base_right = '0;
	sample_t                overlay_left = '0;
	sample_t                overlay_right = '0;
	logic                   overlay_present = 1'b0;
	logic                   target_full = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	sample_t                mixed_left;
	sample_t                mixed_right;
	logic [GAIN_W-1:0]      gain_now;
	logic                   fade_done;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	mix_scoreboard sb = new();

	// Sender and receiver pacing.
	int   tx_gap = 0;
	bit   tx_steady = 1'b0;
	bit   rx_steady = 1'b0;
	int   rx_stall = 0;
	bit   valid_held = 1'b0;  // in_valid left high after the last acceptance
	logic aim_full = 1'b1;

	fading_stereo_overlay_mixer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.base_left       (base_left),
		.base_right      (base_right),
		.overlay_left    (overlay_left),
		.overlay_right   (overlay_right),
		.overlay_present (overlay_present),
		.target_full     (target_full),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mixed_left      (mixed_left),
		.mixed_right     (mixed_right),
		.gain_now        (gain_now),
		.fade_done       (fade_done),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #2 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(12, 40);
	endfunction

	// Receiver: stall for random stretches unless this phase runs it steady.
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			out_ready <= 1'b0;
			rx_stall = rx_stall - 1;
		end else if (!rx_steady && $urandom_range(0, 99) < 20) begin
			out_ready <= 1'b0;
			rx_stall = gap_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Predict on every accepted request; check every accepted result.
	always @(posedge clk)
		if (arst_n && in_valid && in_ready)
			sb.note_request(frame_t'{base_left, base_right, overlay_left, overlay_right,
				overlay_present, target_full});

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(mix_t'{mixed_left, mixed_right, gain_now, fade_done});

	// Present one request and hold it until the block takes it.
	task automatic send_frame(frame_t f);
		if (tx_gap > 0)
			repeat (tx_gap) @(posedge clk);
		in_valid        <= 1'b1;
		base_left       <= f.base_left;
		base_right      <= f.base_right;
		overlay_left    <= f.overlay_left;
		overlay_right   <= f.overlay_right;
		overlay_present <= f.present;
		target_full     <= f.full;
		do
			@(posedge clk);
		while (!in_ready);
		// Decide the next gap now, so valid stays up across back-to-back requests.
		tx_gap = tx_steady ? 0 : gap_len();
		if (tx_gap > 0) begin
			in_valid  <= 1'b0;
			valid_held = 1'b0;
		end else begin
			valid_held = 1'b1;
		end
	endtask

	// Drop valid, wait for every outstanding result, then let the pipeline settle.
	task automatic drain_results();
		if (valid_held) begin
			in_valid  <= 1'b0;
			valid_held = 1'b0;
		end
		// Let the scoreboard note a request taken at this same edge.
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; call only while idle.
	task automatic program_regs(logic [CFG_DATA_W-1:0] up, logic [CFG_DATA_W-1:0] down,
			logic [CFG_DATA_W-1:0] lvl, logic [CFG_DATA_W-1:0] th);
		logic [CFG_INDEX_W-1:0] idx[4];
		logic [CFG_DATA_W-1:0]  val[4];
		idx = '{REG_RAMP_UP, REG_RAMP_DOWN, REG_MIX_LEVEL, REG_SWITCH_TH};
		val = '{up, down, lvl, th};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic frame_t make_frame(int bl, int br, int ol, int orr, bit p, bit f);
		frame_t fr;
		fr.base_left     = sample_t'(bl);
		fr.base_right    = sample_t'(br);
		fr.overlay_left  = sample_t'(ol);
		fr.overlay_right = sample_t'(orr);
		fr.present       = p;
		fr.full          = f;
		return fr;
	endfunction

	// Lean on the extremes, zero and minus one; otherwise any value.
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 11))
			0: return sample_t'(16'h8000);
			1: return sample_t'(16'h7FFF);
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic frame_t random_frame();
		frame_t fr;
		fr.base_left     = pick_sample();
		fr.base_right    = pick_sample();
		fr.overlay_left  = pick_sample();
		fr.overlay_right = pick_sample();
		fr.present       = ($urandom_range(0, 9) < 8);
		fr.full          = aim_full;
		return fr;
	endfunction

	// Steps from zero and one up past unity; mid sizes keep the ramps moving.
	function automatic logic [CFG_DATA_W-1:0] pick_step();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CFG_DATA_W'(1);
			2: return UNITY;
			3: return STEP_MAX;
			4, 5, 6: return CFG_DATA_W'($urandom_range(1, 4096));
			default: return CFG_DATA_W'($urandom_range(4096, 1 << 23));
		endcase
	endfunction

	// Level sits in the low bits; fill the upper data bits with noise.
	function automatic logic [CFG_DATA_W-1:0] pick_level();
		logic [LEVEL_BITS-1:0] lvl;
		case ($urandom_range(0, 5))
			0: lvl = '0;
			1: lvl = '1;
			default: lvl = LEVEL_BITS'($urandom);
		endcase
		return {(CFG_DATA_W - LEVEL_BITS)'($urandom), lvl};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return UNITY;
			2: return STEP_MAX;
			default: return CFG_DATA_W'($urandom_range(0, 1 << 24));
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: pass-through with the extremes, then a slow ramp up and down.
		send_frame(make_frame(-32768, 32767, 32767, -32768, 0, 1));
		send_frame(make_frame(32767, -32768, -32768, 32767, 0, 0));
		send_frame(make_frame(0, 0, 32767, -32768, 1, 1));
		send_frame(make_frame(32767, -32768, 32767, -32768, 1, 1));
		send_frame(make_frame(-1, 1, -1, 1, 1, 0));
		send_frame(make_frame(100, -100, 200, -200, 1, 0));

		// Oversized steps clamp at the target; full level drives both rails.
		drain_results();
		program_regs(STEP_MAX, STEP_MAX, CFG_DATA_W'(16'hFFFF), UNITY);
		send_frame(make_frame(32767, -32768, 32767, -32768, 1, 1));
		send_frame(make_frame(-32768, 32767, -32768, 32767, 1, 1));
		send_frame(make_frame(0, 0, -32768, 32767, 1, 1));
		send_frame(make_frame(5, -5, 1234, -1234, 0, 0));
		send_frame(make_frame(0, 0, 12345, -12345, 1, 0));
		send_frame(make_frame(0, 0, 32767, 32767, 1, 0));

		// Zero steps hold the gain; junk above the level bits must be dropped.
		drain_results();
		program_regs('0, '0, {9'h1FF, 16'h8000}, '0);
		send_frame(make_frame(1, 2, 32767, -32768, 1, 1));
		send_frame(make_frame(1, 2, 3, 4, 1, 0));

		// Threshold one below unity: done flips exactly at the boundary.
		drain_results();
		program_regs(UNITY, CFG_DATA_W'(1), CFG_DATA_W'(16'hFFFF), CFG_DATA_W'(UNITY - 1));
		send_frame(make_frame(-7, 7, 30000, -30000, 1, 1));
		send_frame(make_frame(-7, 7, 30000, -30000, 1, 0));
		send_frame(make_frame(-7, 7, 30000, -30000, 1, 0));

		// Random phases, each with its own settings and pacing.
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			program_regs(pick_step(), pick_step(), pick_level(), pick_threshold());
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 66; n++) begin
				if ($urandom_range(0, 63) == 0)
					drain_results();
				if ($urandom_range(0, 11) == 0)
					aim_full = ~aim_full;
				send_frame(random_frame());
			end
		end

		drain_results();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop in case a handshake hangs.
	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/fsom_pkg.sv
rtl/core/fsom_serial_scale.sv
rtl/core/fading_stereo_overlay_mixer.sv
tb/testbench.sv
